>>> rtl/tte_pkg.sv
// Shared constants and types of the tap tempo estimator.
`timescale 1ns / 1ps

package tte_pkg;

	localparam int unsigned TIME_W        = 32;
	localparam int unsigned CFG_W         = 16;
	localparam int unsigned TEMPO_W       = 13;
	localparam int unsigned DIV_SEL_W     = 2;
	localparam int unsigned TAPS_W        = 3;
	localparam int unsigned SER_CNT_W     = 5;
	localparam int unsigned HISTORY_DEPTH = 4;

	localparam int unsigned TEMPO_SCALE = 960000;

	localparam logic [TEMPO_W-1:0]   TEMPO_RESET      = 13'd1920;
	localparam logic [TEMPO_W-1:0]   TEMPO_MIN        = 13'd640;
	localparam logic [TEMPO_W-1:0]   TEMPO_MAX        = 13'd4800;
	localparam logic [CFG_W-1:0]     TIMEOUT_RESET    = 16'd2000;
	localparam logic [CFG_W-1:0]     LONG_PRESS_RESET = 16'd1000;
	localparam logic [DIV_SEL_W-1:0] DIV_SEL_LAST     = 2'd2;

	typedef enum logic {
		REG_TIMEOUT    = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SERIAL,
		ST_DECIDE,
		ST_DIV,
		ST_CLAMP,
		ST_OUT
	} state_t;

	// Strobes from the sequencer to the datapath.
	typedef struct packed {
		logic accept;
		logic load;
		logic shift;
		logic decide;
		logic div_step;
		logic clamp;
		logic publish;
	} ctrl_t;

endpackage

>>> rtl/tte_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
`timescale 1ns / 1ps

interface tte_in_if;
	logic                           valid;
	logic                           ready;
	logic [tte_pkg::TIME_W-1:0]     now_ms;
	logic                           switch_level;

	modport source (output valid, output now_ms, output switch_level, input ready);
	modport sink   (input valid, input now_ms, input switch_level, output ready);
endinterface

interface tte_out_if;
	logic                           valid;
	logic                           ready;
	logic [tte_pkg::TEMPO_W-1:0]    tempo_x16;
	logic                           new_tempo;
	logic [tte_pkg::DIV_SEL_W-1:0]  division_sel;
	logic [tte_pkg::TAPS_W-1:0]     taps_held;

	modport source (output valid, output tempo_x16, output new_tempo, output division_sel,
		output taps_held, input ready);
	modport sink   (input valid, input tempo_x16, input new_tempo, input division_sel,
		input taps_held, output ready);
endinterface

>>> rtl/tte_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module tte_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tap_tempo_estimator_unit.sv
// Tap tempo estimator: a bit-serial time datapath with an iterative tempo divider.
`timescale 1ns / 1ps

// One beat on tick is one millisecond tick: a time stamp and the debounced tap switch
// level (0 = pressed). Every tick yields one result beat with the tempo in 1/16 BPM, a
// fresh-tempo flag, the division selection and the number of taps held. A tick runs
// the bit-serial pass that forms the three wrapped time differences (tap age, press
// age and tap span) one bit per cycle; when a tap produces a fresh tempo, the restoring
// divider then yields one quotient bit per cycle. The next tick is accepted once the
// result sits in the output register. Configuration writes are to be taken only while
// no tick is in work; the user is bound to this, the block itself does not enforce it.
module tap_tempo_estimator_unit #(
	parameter int unsigned HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	tte_in_if.sink                   tick,
	tte_out_if.source                result,
	input  logic                     cfg_wr_en,
	input  logic                     cfg_index,
	input  logic [tte_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned TW     = tte_pkg::TIME_W;
	localparam int unsigned CW     = tte_pkg::CFG_W;
	localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned IW     = SLOT_W + 1;
	localparam int unsigned NUM_W  = $clog2(tte_pkg::TEMPO_SCALE * (HISTORY_DEPTH - 1) + 1);
	localparam int unsigned SCW    = tte_pkg::SER_CNT_W;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HISTORY_DEPTH);
	localparam logic [IW-1:0]     IDX_DEPTH = IW'(HISTORY_DEPTH);
	localparam logic [NUM_W-1:0]  SCALE_N   = NUM_W'(tte_pkg::TEMPO_SCALE);
	localparam logic [SCW-1:0]    SER_LAST  = SCW'(TW - 1);
	localparam logic [SCW-1:0]    DIV_LAST  = SCW'(NUM_W - 1);

	tte_pkg::state_t state_q, state_d;
	tte_pkg::ctrl_t  ctrl;

	// Configuration registers.
	logic [CW-1:0] timeout_q, long_press_q;

	// Architectural state.
	logic [SLOT_W-1:0]             slot_q;
	logic [CNT_W-1:0]              total_q;
	logic                          prior_q;
	logic [TW-1:0]                 press_stamp_q;
	logic                          armed_q;
	logic [tte_pkg::DIV_SEL_W-1:0] div_idx_q;
	logic                          div_done_q;
	logic [tte_pkg::TEMPO_W-1:0]   tempo_q;
	logic [TW-1:0]                 newest_q;

	// Per-tick working registers.
	logic          lvl_q;
	logic          fresh_q;
	logic [SCW-1:0] cnt_q;
	logic [TW-1:0] now_sh_q, newest_sh_q, press_sh_q, oldest_sh_q, span_sh_q;
	logic [CW-1:0] tmo_sh_q, lp_sh_q;
	logic          br_age_q, br_press_q, br_span_q;
	logic          age_gt_q, press_gt_q, span_nz_q;
	logic [NUM_W-1:0] num_sh_q;
	logic [TW-1:0]    rem_q;

	// Output register.
	logic                          res_valid_q;
	logic [tte_pkg::TEMPO_W-1:0]   res_tempo_q;
	logic                          res_new_q;
	logic [tte_pkg::DIV_SEL_W-1:0] res_div_q;
	logic [tte_pkg::TAPS_W-1:0]    res_taps_q;

	// History slot arithmetic for a tap that follows no timeout.
	logic [SLOT_W-1:0] slot_next;
	logic [CNT_W-1:0]  total_next;
	logic [IW-1:0]     old_tmp;
	logic [SLOT_W-1:0] old_idx;

	assign slot_next  = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
	assign total_next = (total_q == CNT_FULL) ? CNT_FULL : total_q + 1'b1;
	assign old_tmp    = IW'(slot_next) + IDX_DEPTH - IW'(total_next);
	assign old_idx    = (old_tmp >= IDX_DEPTH) ? SLOT_W'(old_tmp - IDX_DEPTH)
		: SLOT_W'(old_tmp);

	// Tick classification.
	logic fall, hold, rise, timed_out, do_div;
	assign fall      = !lvl_q && prior_q;
	assign hold      = !lvl_q && !prior_q;
	assign rise      = lvl_q && !prior_q;
	assign timed_out = (total_q != '0) && age_gt_q;
	assign do_div    = fall && !timed_out && (total_next >= CNT_W'(2)) && span_nz_q;

	logic [SLOT_W-1:0] slot_base;
	assign slot_base = timed_out ? '0 : slot_q;

	// History memory: written by a tap, read at the oldest entry the tap will span.
	logic [TW-1:0] oldest_rd;
	logic          ram_we;
	assign ram_we = ctrl.decide && fall;

	tte_ram #(
		.WIDTH (TW),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_base),
		.wdata (now_sh_q),
		.raddr (old_idx),
		.rdata (oldest_rd)
	);

	// Bit-serial subtractors, least significant bit first.
	logic a_bit, d_age, d_press, d_span;
	assign a_bit   = now_sh_q[0];
	assign d_age   = a_bit ^ newest_sh_q[0] ^ br_age_q;
	assign d_press = a_bit ^ press_sh_q[0] ^ br_press_q;
	assign d_span  = a_bit ^ oldest_sh_q[0] ^ br_span_q;

	function automatic logic borrow_out(input logic a, input logic b, input logic bin);
		borrow_out = (!a && b) || (!(a ^ b) && bin);
	endfunction

	// Restoring division step.
	logic [TW:0]      rem_trial;
	logic             q_bit;
	logic [NUM_W-1:0] num_init;
	logic [CNT_W-1:0] total_m1;

	assign rem_trial = {rem_q, num_sh_q[NUM_W-1]};
	assign q_bit     = (rem_trial >= {1'b0, span_sh_q});
	assign total_m1  = total_next - 1'b1;
	assign num_init  = SCALE_N * NUM_W'(total_m1);

	logic [CNT_W+2:0] taps_wide;
	assign taps_wide = (CNT_W + 3)'(total_q);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tte_pkg::ST_IDLE: begin
				if (tick.valid) begin
					state_d = tte_pkg::ST_LOAD;
				end
			end
			tte_pkg::ST_LOAD: begin
				state_d = tte_pkg::ST_SERIAL;
			end
			tte_pkg::ST_SERIAL: begin
				if (cnt_q == SER_LAST) begin
					state_d = tte_pkg::ST_DECIDE;
				end
			end
			tte_pkg::ST_DECIDE: begin
				state_d = do_div ? tte_pkg::ST_DIV : tte_pkg::ST_OUT;
			end
			tte_pkg::ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = tte_pkg::ST_CLAMP;
				end
			end
			tte_pkg::ST_CLAMP: begin
				state_d = tte_pkg::ST_OUT;
			end
			tte_pkg::ST_OUT: begin
				if (!res_valid_q || result.ready) begin
					state_d = tte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tte_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer: strobes.
	always_comb begin
		ctrl       = '0;
		tick.ready = 1'b0;
		unique case (state_q)
			tte_pkg::ST_IDLE: begin
				tick.ready  = 1'b1;
				ctrl.accept = tick.valid;
			end
			tte_pkg::ST_LOAD:   ctrl.load     = 1'b1;
			tte_pkg::ST_SERIAL: ctrl.shift    = 1'b1;
			tte_pkg::ST_DECIDE: ctrl.decide   = 1'b1;
			tte_pkg::ST_DIV:    ctrl.div_step = 1'b1;
			tte_pkg::ST_CLAMP:  ctrl.clamp    = 1'b1;
			tte_pkg::ST_OUT:    ctrl.publish  = !res_valid_q || result.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= tte_pkg::TIMEOUT_RESET;
			long_press_q <= tte_pkg::LONG_PRESS_RESET;
		end else if (cfg_wr_en) begin
			unique case (tte_pkg::reg_index_t'(cfg_index))
				tte_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data;
				tte_pkg::REG_LONG_PRESS: long_press_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Architectural state update, once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q        <= '0;
			total_q       <= '0;
			prior_q       <= 1'b0;
			press_stamp_q <= '0;
			armed_q       <= 1'b0;
			div_idx_q     <= '0;
			div_done_q    <= 1'b0;
			tempo_q       <= tte_pkg::TEMPO_RESET;
			fresh_q       <= 1'b0;
		end else begin
			if (ctrl.decide) begin
				fresh_q <= 1'b0;
				prior_q <= lvl_q;
				if (timed_out) begin
					slot_q  <= '0;
					total_q <= '0;
				end
				if (fall) begin
					slot_q        <= (slot_base == SLOT_LAST) ? '0 : slot_base + 1'b1;
					total_q       <= timed_out ? CNT_W'(1) : total_next;
					press_stamp_q <= now_sh_q;
					armed_q       <= 1'b1;
				end
				if (hold && armed_q && press_gt_q && !div_done_q) begin
					div_idx_q  <= (div_idx_q == tte_pkg::DIV_SEL_LAST) ? '0
						: div_idx_q + 1'b1;
					div_done_q <= 1'b1;
				end
				if (rise) begin
					div_done_q    <= 1'b0;
					armed_q       <= 1'b0;
					press_stamp_q <= '0;
				end
			end
			if (ctrl.clamp) begin
				fresh_q <= 1'b1;
				if (num_sh_q < NUM_W'(tte_pkg::TEMPO_MIN)) begin
					tempo_q <= tte_pkg::TEMPO_MIN;
				end else if (num_sh_q > NUM_W'(tte_pkg::TEMPO_MAX)) begin
					tempo_q <= tte_pkg::TEMPO_MAX;
				end else begin
					tempo_q <= tte_pkg::TEMPO_W'(num_sh_q);
				end
			end
		end
	end

	// Newest tap stamp; its value matters only while taps are held.
	always_ff @(posedge clk) begin
		if (ctrl.decide && fall) begin
			newest_q <= now_sh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.accept || ctrl.decide) begin
			cnt_q <= '0;
		end else if (ctrl.shift || ctrl.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Serial datapath and divider.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			now_sh_q    <= tick.now_ms;
			lvl_q       <= tick.switch_level;
			newest_sh_q <= newest_q;
			press_sh_q  <= press_stamp_q;
			tmo_sh_q    <= timeout_q;
			lp_sh_q     <= long_press_q;
			br_age_q    <= 1'b0;
			br_press_q  <= 1'b0;
			br_span_q   <= 1'b0;
			age_gt_q    <= 1'b0;
			press_gt_q  <= 1'b0;
			span_nz_q   <= 1'b0;
		end
		if (ctrl.load) begin
			oldest_sh_q <= oldest_rd;
		end
		if (ctrl.shift) begin
			// The time stamp rotates so it is whole again when the pass ends.
			now_sh_q    <= {now_sh_q[0], now_sh_q[TW-1:1]};
			newest_sh_q <= {1'b0, newest_sh_q[TW-1:1]};
			press_sh_q  <= {1'b0, press_sh_q[TW-1:1]};
			oldest_sh_q <= {1'b0, oldest_sh_q[TW-1:1]};
			tmo_sh_q    <= {1'b0, tmo_sh_q[CW-1:1]};
			lp_sh_q     <= {1'b0, lp_sh_q[CW-1:1]};
			span_sh_q   <= {d_span, span_sh_q[TW-1:1]};
			br_age_q    <= borrow_out(a_bit, newest_sh_q[0], br_age_q);
			br_press_q  <= borrow_out(a_bit, press_sh_q[0], br_press_q);
			br_span_q   <= borrow_out(a_bit, oldest_sh_q[0], br_span_q);
			// Magnitude compare: the highest differing bit decides.
			if (d_age != tmo_sh_q[0]) begin
				age_gt_q <= d_age;
			end
			if (d_press != lp_sh_q[0]) begin
				press_gt_q <= d_press;
			end
			span_nz_q <= span_nz_q | d_span;
		end
		if (ctrl.decide) begin
			num_sh_q <= num_init;
			rem_q    <= '0;
		end
		if (ctrl.div_step) begin
			// The quotient bits fill in behind the numerator as it shifts out.
			num_sh_q <= {num_sh_q[NUM_W-2:0], q_bit};
			rem_q    <= q_bit ? TW'(rem_trial - {1'b0, span_sh_q}) : TW'(rem_trial);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.publish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.publish) begin
			res_tempo_q <= tempo_q;
			res_new_q   <= fresh_q;
			res_div_q   <= div_idx_q;
			res_taps_q  <= taps_wide[2:0];
		end
	end

	assign result.valid        = res_valid_q;
	assign result.tempo_x16    = res_tempo_q;
	assign result.new_tempo    = res_new_q;
	assign result.division_sel = res_div_q;
	assign result.taps_held    = res_taps_q;

endmodule

>>> verif/tb_tap_tempo_estimator_unit.sv
// Self-checking testbench for the tap tempo estimator: directed and random ticks, scored in order.
`timescale 1ns / 1ps

module tb_tap_tempo_estimator_unit;

	typedef struct packed {
		logic [tte_pkg::TIME_W-1:0] now_ms;
		logic                       switch_level;
	} tick_item_t;

	typedef struct packed {
		logic [tte_pkg::TEMPO_W-1:0]   tempo_x16;
		logic                          new_tempo;
		logic [tte_pkg::DIV_SEL_W-1:0] division_sel;
		logic [tte_pkg::TAPS_W-1:0]    taps_held;
	} tempo_readout_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	tte_pkg::reg_index_t cfg_index;
	logic [tte_pkg::CFG_W-1:0] cfg_data;

	tte_in_if  tick_bus ();
	tte_out_if result_bus ();

	tap_tempo_estimator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_bus),
		.result    (result_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tick_item_t     tick_backlog[$];
	tempo_readout_t expected_readouts[$];
	tick_item_t     next_tick;
	tempo_readout_t seen_readout;
	tempo_readout_t wanted_readout;

	int unsigned send_idle_pct = 9;
	int unsigned recv_idle_pct = 56;
	int unsigned mismatch_count = 0;
	int unsigned readout_index = 0;
	int unsigned queued_count = 0;

	// Mirror of the block's state and registers.
	logic [tte_pkg::CFG_W-1:0]     timeout_cfg = tte_pkg::TIMEOUT_RESET;
	logic [tte_pkg::CFG_W-1:0]     long_press_cfg = tte_pkg::LONG_PRESS_RESET;
	logic [tte_pkg::TIME_W-1:0]    stamp_ring[tte_pkg::HISTORY_DEPTH];
	int unsigned                   ring_slot = 0;
	int unsigned                   ring_count = 0;
	logic                          level_last = 1'b0;
	logic [tte_pkg::TIME_W-1:0]    press_time = '0;
	logic                          press_live = 1'b0;
	logic [tte_pkg::DIV_SEL_W-1:0] div_index = '0;
	logic                          div_latched = 1'b0;
	logic [tte_pkg::TEMPO_W-1:0]   tempo_now = tte_pkg::TEMPO_RESET;

	// Stimulus generator position.
	logic [tte_pkg::TIME_W-1:0] gen_ms = '0;
	logic                       gen_level = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned ring_back(int unsigned slot, int unsigned steps);
		return (slot + 2 * tte_pkg::HISTORY_DEPTH - steps) % tte_pkg::HISTORY_DEPTH;
	endfunction

	function automatic tempo_readout_t predict_tempo_tick(logic [tte_pkg::TIME_W-1:0] now,
		logic level);
		tempo_readout_t r;
		logic [tte_pkg::TIME_W-1:0] age;
		logic [tte_pkg::TIME_W-1:0] span;
		longint unsigned quot;
		r.new_tempo = 1'b0;

		if (ring_count != 0) begin
			age = now - stamp_ring[ring_back(ring_slot, 1)];
			if (age > tte_pkg::TIME_W'(timeout_cfg)) begin
				ring_count = 0;
				ring_slot = 0;
			end
		end

		if (!level && level_last) begin
			press_time = now;
			press_live = 1'b1;
			stamp_ring[ring_slot] = now;
			ring_slot = (ring_slot + 1) % tte_pkg::HISTORY_DEPTH;
			if (ring_count < tte_pkg::HISTORY_DEPTH)
				ring_count++;
			if (ring_count >= 2) begin
				span = stamp_ring[ring_back(ring_slot, 1)]
					- stamp_ring[ring_back(ring_slot, ring_count)];
				if (span != 0) begin
					quot = (64'(tte_pkg::TEMPO_SCALE) * 64'(ring_count - 1)) / 64'(span);
					if (quot < 64'(tte_pkg::TEMPO_MIN))
						quot = 64'(tte_pkg::TEMPO_MIN);
					if (quot > 64'(tte_pkg::TEMPO_MAX))
						quot = 64'(tte_pkg::TEMPO_MAX);
					tempo_now = quot[tte_pkg::TEMPO_W-1:0];
					r.new_tempo = 1'b1;
				end
			end
		end

		if (!level && !level_last) begin
			age = now - press_time;
			if (press_live && age > tte_pkg::TIME_W'(long_press_cfg) && !div_latched) begin
				div_index = (div_index == tte_pkg::DIV_SEL_LAST) ? '0 : div_index + 1'b1;
				div_latched = 1'b1;
			end
		end

		if (level && !level_last) begin
			div_latched = 1'b0;
			press_live = 1'b0;
			press_time = '0;
		end

		level_last = level;
		r.tempo_x16 = tempo_now;
		r.division_sel = div_index;
		r.taps_held = ring_count[tte_pkg::TAPS_W-1:0];
		return r;
	endfunction

	// Tick driver: prediction happens on the accepting edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
		end else begin
			if (tick_bus.valid && tick_bus.ready)
				expected_readouts.push_back(predict_tempo_tick(tick_bus.now_ms,
					tick_bus.switch_level));
			if (!tick_bus.valid || tick_bus.ready) begin
				if (tick_backlog.size() != 0 &&
						(send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct)) begin
					next_tick = tick_backlog.pop_front();
					tick_bus.valid <= 1'b1;
					tick_bus.now_ms <= next_tick.now_ms;
					tick_bus.switch_level <= next_tick.switch_level;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// Result monitor and scoreboard.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				seen_readout.tempo_x16 = result_bus.tempo_x16;
				seen_readout.new_tempo = result_bus.new_tempo;
				seen_readout.division_sel = result_bus.division_sel;
				seen_readout.taps_held = result_bus.taps_held;
				if (expected_readouts.size() == 0) begin
					flag_mismatch($sformatf("unexpected result beat: tempo %0d new %0b div %0d taps %0d",
						seen_readout.tempo_x16, seen_readout.new_tempo,
						seen_readout.division_sel, seen_readout.taps_held));
				end else begin
					wanted_readout = expected_readouts.pop_front();
					if (seen_readout.tempo_x16 !== wanted_readout.tempo_x16 ||
							seen_readout.new_tempo !== wanted_readout.new_tempo ||
							seen_readout.division_sel !== wanted_readout.division_sel ||
							seen_readout.taps_held !== wanted_readout.taps_held)
						flag_mismatch($sformatf({"readout %0d: expected tempo %0d new %0b div %0d",
							" taps %0d, got tempo %0d new %0b div %0d taps %0d"}, readout_index,
							wanted_readout.tempo_x16, wanted_readout.new_tempo,
							wanted_readout.division_sel, wanted_readout.taps_held,
							seen_readout.tempo_x16, seen_readout.new_tempo,
							seen_readout.division_sel, seen_readout.taps_held));
				end
				readout_index++;
			end
			result_bus.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_tick(logic [tte_pkg::TIME_W-1:0] now, logic level);
		tick_item_t item;
		item.now_ms = now;
		item.switch_level = level;
		tick_backlog.push_back(item);
		gen_ms = now;
		gen_level = level;
		queued_count++;
	endtask

	// A run of taps at a roughly steady interval, from zero span up past the timeout.
	task automatic queue_tap_burst();
		int unsigned taps;
		int unsigned gap;
		int unsigned gap_i;
		int unsigned hold;
		int unsigned i;
		logic [tte_pkg::TIME_W-1:0] t;
		taps = $urandom_range(2, 6);
		case ($urandom_range(9))
			0: gap = $urandom_range(0, 3);
			1: gap = $urandom_range(4, 199);
			2: gap = $urandom_range(1500, 32'(timeout_cfg) + 200);
			default: gap = $urandom_range(200, 1500);
		endcase
		if (!gen_level)
			push_tick(gen_ms + $urandom_range(1, 50), 1'b1);
		t = gen_ms + $urandom_range(1, 3000);
		for (i = 0; i < taps; i++) begin
			gap_i = gap + $urandom_range(0, gap / 8);
			push_tick(t, 1'b0);
			hold = $urandom_range(0, gap_i);
			if ($urandom_range(3) == 0)
				push_tick(t + hold / 2, 1'b0);
			push_tick(t + hold, 1'b1);
			if ($urandom_range(2) == 0 && hold < gap_i)
				push_tick(t + hold + $urandom_range(0, gap_i - hold), 1'b1);
			t = t + gap_i;
		end
	endtask

	// Hold the switch across the long-press limit, sometimes landing exactly on it.
	task automatic queue_long_press();
		logic [tte_pkg::TIME_W-1:0] t;
		if (!gen_level)
			push_tick(gen_ms + $urandom_range(1, 20), 1'b1);
		t = gen_ms + $urandom_range(1, 500);
		push_tick(t, 1'b0);
		if ($urandom_range(1))
			push_tick(t + long_press_cfg, 1'b0);
		push_tick(t + long_press_cfg + 1 + $urandom_range(0, 3), 1'b0);
		push_tick(gen_ms + $urandom_range(0, 3000), 1'b0);
		push_tick(gen_ms + $urandom_range(0, 20), 1'b1);
	endtask

	// Second tap exactly at the timeout or one millisecond past it.
	task automatic queue_timeout_edge();
		logic [tte_pkg::TIME_W-1:0] t;
		if (!gen_level)
			push_tick(gen_ms + $urandom_range(1, 20), 1'b1);
		t = gen_ms + $urandom_range(1, 100);
		push_tick(t, 1'b0);
		push_tick(t, 1'b1);
		t = t + timeout_cfg + $urandom_range(0, 1);
		push_tick(t, 1'b0);
		push_tick(t, 1'b1);
	endtask

	task automatic queue_noise();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(1, 4);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0)
				push_tick($urandom(), 1'($urandom_range(1)));
			else
				push_tick(gen_ms + $urandom_range(0, 100), 1'($urandom_range(1)));
		end
	endtask

	task automatic queue_random_ticks(int unsigned count);
		int unsigned start;
		int unsigned pick;
		start = queued_count;
		while (queued_count - start < count) begin
			pick = $urandom_range(99);
			if (pick < 60)
				queue_tap_burst();
			else if (pick < 75)
				queue_long_press();
			else if (pick < 85)
				queue_timeout_edge();
			else
				queue_noise();
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (tick_backlog.size() != 0 || tick_bus.valid || expected_readouts.size() != 0);
	endtask

	task automatic write_reg(tte_pkg::reg_index_t idx, logic [tte_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == tte_pkg::REG_TIMEOUT)
			timeout_cfg = value;
		else
			long_press_cfg = value;
	endtask

	initial begin
		foreach (stamp_ring[k])
			stamp_ring[k] = '0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = tte_pkg::REG_TIMEOUT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Held low since reset: neither a tap nor a long press.
		push_tick(32'd5000, 1'b0);
		push_tick(32'd9000, 1'b0);
		push_tick(32'd9001, 1'b1);
		// Four taps filling the history, then a fifth that overwrites the oldest.
		push_tick(32'd10000, 1'b0);
		push_tick(32'd10100, 1'b1);
		push_tick(32'd10500, 1'b0);
		push_tick(32'd10600, 1'b1);
		push_tick(32'd10650, 1'b0);
		push_tick(32'd10651, 1'b1);
		push_tick(32'd10700, 1'b0);
		push_tick(32'd10701, 1'b1);
		push_tick(32'd10750, 1'b0);
		// Timeout clears the history, then two taps at the same millisecond.
		push_tick(32'd20000, 1'b1);
		push_tick(32'd20000, 1'b0);
		push_tick(32'd20000, 1'b1);
		push_tick(32'd20000, 1'b0);
		// Slow taps exactly at the timeout clamp to the minimum tempo.
		push_tick(32'd22001, 1'b1);
		push_tick(32'd22001, 1'b0);
		push_tick(32'd22002, 1'b1);
		push_tick(32'd24001, 1'b0);
		// Long press: at the limit nothing happens, one past it advances once.
		push_tick(32'd25001, 1'b0);
		push_tick(32'd25002, 1'b0);
		push_tick(32'd40000, 1'b0);
		push_tick(32'd40001, 1'b1);
		// Tap span across the wrap of the time stamp.
		push_tick(32'hFFFF_FF00, 1'b0);
		push_tick(32'hFFFF_FFFF, 1'b1);
		push_tick(32'h0000_0000, 1'b0);
		wait_idle();

		for (int phase = 1; phase <= 6; phase++) begin
			case (phase)
				1: begin
					write_reg(tte_pkg::REG_TIMEOUT, 16'hFFFF);
					write_reg(tte_pkg::REG_LONG_PRESS, 16'd1);
				end
				2: begin
					write_reg(tte_pkg::REG_TIMEOUT, 16'd1);
					write_reg(tte_pkg::REG_LONG_PRESS, 16'hFFFF);
				end
				3: begin
					write_reg(tte_pkg::REG_TIMEOUT, 16'd3000);
					write_reg(tte_pkg::REG_LONG_PRESS, 16'd500);
				end
				4: begin
					write_reg(tte_pkg::REG_TIMEOUT, 16'($urandom_range(200, 65535)));
					write_reg(tte_pkg::REG_LONG_PRESS, 16'($urandom_range(1, 5000)));
				end
				5: begin
					write_reg(tte_pkg::REG_TIMEOUT, tte_pkg::TIMEOUT_RESET);
					write_reg(tte_pkg::REG_LONG_PRESS, tte_pkg::LONG_PRESS_RESET);
				end
				default: begin
					write_reg(tte_pkg::REG_TIMEOUT, 16'($urandom_range(1, 65535)));
					write_reg(tte_pkg::REG_LONG_PRESS, 16'($urandom_range(1, 65535)));
				end
			endcase
			@(negedge clk);
			if (phase <= 2) begin
				send_idle_pct = 9;
				recv_idle_pct = 56;
			end else if (phase <= 4) begin
				send_idle_pct = 56;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Run the time stamp through its wrap during this phase.
			if (phase == 3)
				gen_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			queue_random_ticks(85);
			// Let every result come home before the rest of the phase goes out.
			wait_idle();
			queue_random_ticks(85);
			wait_idle();
		end

		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && expected_readouts.size() == 0) begin
			$display("tap_tempo_estimator_unit test passed");
		end else begin
			$display("tap_tempo_estimator_unit test failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tap_tempo_estimator_unit test failed");
		$finish;
	end

endmodule

>>> tap_tempo_estimator_unit.f
rtl/tte_pkg.sv
rtl/tte_if.sv
rtl/tte_ram.sv
rtl/tap_tempo_estimator_unit.sv
verif/tb_tap_tempo_estimator_unit.sv
